// ===== rtl/axui_pkg.sv =====
// Shared types, constants and the FCS byte update for the AX.25 UI frame builder.
// No dependencies; every other file imports this package.
package axui_pkg;

    // Frame octets
    localparam logic [7:0]  FLAG_OCTET    = 8'h7E;
    localparam logic [7:0]  CTRL_UI       = 8'h03;
    localparam logic [7:0]  PID_NO_L3     = 8'hF0;
    localparam logic [7:0]  SSID_BASE     = 8'h60;
    localparam logic [7:0]  ADDR_END_BIT  = 8'h01;
    localparam logic [7:0]  SPACE_SHIFTED = 8'h40;
    localparam logic [15:0] FCS_INIT      = 16'hFFFF;
    localparam logic [15:0] FCS_POLY_REFL = 16'h8408;

    // Widths
    localparam int CALL_W = 48;
    localparam int SSID_W = 4;
    localparam int CFG_W  = 48;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_CALL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_SSID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CALL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_SSID  = 2'd3;

    // Byte positions within one input beat's run of output bytes
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_OPEN      = 5'd0;
    localparam logic [STEP_W-1:0] STEP_DEST0     = 5'd1;
    localparam logic [STEP_W-1:0] STEP_DEST_SSID = 5'd7;
    localparam logic [STEP_W-1:0] STEP_SRC0      = 5'd8;
    localparam logic [STEP_W-1:0] STEP_SRC_SSID  = 5'd14;
    localparam logic [STEP_W-1:0] STEP_CTRL      = 5'd15;
    localparam logic [STEP_W-1:0] STEP_PID       = 5'd16;
    localparam logic [STEP_W-1:0] STEP_INFO      = 5'd17;
    localparam logic [STEP_W-1:0] STEP_FCS_LO    = 5'd18;
    localparam logic [STEP_W-1:0] STEP_FCS_HI    = 5'd19;
    localparam logic [STEP_W-1:0] STEP_CLOSE     = 5'd20;

    typedef struct packed {
        logic [7:0] info_byte;
        logic       info_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       run_end;
    } out_beat_t;

    // Address configuration handed to the header generator
    typedef struct packed {
        logic [CALL_W-1:0] dst_call;
        logic [SSID_W-1:0] dst_ssid;
        logic [CALL_W-1:0] orig_call;
        logic [SSID_W-1:0] orig_ssid;
    } addr_cfg_t;

    // CRC-16/X.25, LSB first, one byte
    function automatic logic [15:0] fcs_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ FCS_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/axui_hdr_byte.sv =====
// Header octet generator: flag, two address fields, control and PID by position.
// Depends on axui_pkg.
module axui_hdr_byte
    import axui_pkg::*;
(
    input  addr_cfg_t          cfg,
    input  logic [STEP_W-1:0]  step,
    output logic [7:0]         hdr_byte
);

    logic [5:0] dest_pad;
    logic [5:0] src_pad;
    logic [7:0] dest_chr [6];
    logic [7:0] src_chr  [6];
    logic [7:0] dest_ssid_oct;
    logic [7:0] src_ssid_oct;
    logic [STEP_W-1:0] dest_pos;
    logic [STEP_W-1:0] src_pos;

    // Padding starts at the first zero character and runs to the end
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            dest_chr[i] = cfg.dst_call[CALL_W-1-8*i -: 8];
            src_chr[i]  = cfg.orig_call[CALL_W-1-8*i -: 8];
        end
        dest_pad[0] = (dest_chr[0] == 8'h00);
        src_pad[0]  = (src_chr[0] == 8'h00);
        for (int i = 1; i < 6; i++)
        begin
            dest_pad[i] = (dest_chr[i] == 8'h00) | dest_pad[i-1];
            src_pad[i]  = (src_chr[i] == 8'h00)  | src_pad[i-1];
        end
    end

    assign dest_ssid_oct = SSID_BASE | {3'b000, cfg.dst_ssid, 1'b0};
    assign src_ssid_oct  = SSID_BASE | {3'b000, cfg.orig_ssid, 1'b0} | ADDR_END_BIT;

    assign dest_pos = step - STEP_DEST0;
    assign src_pos  = step - STEP_SRC0;

    // Octet select by position
    always_comb
    begin
        hdr_byte = FLAG_OCTET;
        if (step >= STEP_DEST0 && step < STEP_DEST_SSID)
            hdr_byte = dest_pad[dest_pos[2:0]] ? SPACE_SHIFTED
                                               : {dest_chr[dest_pos[2:0]][6:0], 1'b0};
        else if (step == STEP_DEST_SSID)
            hdr_byte = dest_ssid_oct;
        else if (step >= STEP_SRC0 && step < STEP_SRC_SSID)
            hdr_byte = src_pad[src_pos[2:0]] ? SPACE_SHIFTED
                                             : {src_chr[src_pos[2:0]][6:0], 1'b0};
        else if (step == STEP_SRC_SSID)
            hdr_byte = src_ssid_oct;
        else if (step == STEP_CTRL)
            hdr_byte = CTRL_UI;
        else if (step == STEP_PID)
            hdr_byte = PID_NO_L3;
    end

endmodule

// ===== rtl/ax25_ui_frame_builder_unit.sv =====
// AX.25 UI frame builder top level: input beat register, byte sequencer, FCS, output register.
// Depends on axui_pkg and axui_hdr_byte.
// Throughput: one output byte per cycle while out_ready does not stall the output register;
//   a beat yields 1 byte mid-frame, 18 on the first byte of a frame, 4 on the last,
//   21 for a one-byte frame; the byte sequencer sets this.
// Reset: asynchronous, active low; address registers clear to zero, no frame open, FCS 0xFFFF.
module ax25_ui_frame_builder_unit
    import axui_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data
);

    addr_cfg_t         cfg_reg;
    in_beat_t          item_reg;
    logic              item_valid_reg, item_valid_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              frame_open_reg, frame_open_next;
    logic [15:0]       fcs_reg, fcs_next;
    out_beat_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              in_fire;
    logic              emit;
    logic              last_step;
    logic [STEP_W-1:0] end_step;
    logic [7:0]        hdr_byte;
    logic [7:0]        cur_byte;
    logic [15:0]       fcs_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEST_CALL: cfg_reg.dst_call  <= cfg_data[CALL_W-1:0];
                CFG_DEST_SSID: cfg_reg.dst_ssid  <= cfg_data[SSID_W-1:0];
                CFG_SRC_CALL:  cfg_reg.orig_call <= cfg_data[CALL_W-1:0];
                CFG_SRC_SSID:  cfg_reg.orig_ssid <= cfg_data[SSID_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    axui_hdr_byte u_hdr (
        .cfg      (cfg_reg),
        .step     (step_reg),
        .hdr_byte (hdr_byte)
    );

    // Byte for the current position
    assign fcs_out = ~fcs_reg;
    always_comb
    begin
        unique case (step_reg)
            STEP_INFO:   cur_byte = item_reg.info_byte;
            STEP_FCS_LO: cur_byte = fcs_out[7:0];
            STEP_FCS_HI: cur_byte = fcs_out[15:8];
            STEP_CLOSE:  cur_byte = FLAG_OCTET;
            default:     cur_byte = hdr_byte;
        endcase
    end

    // Handshake and sequencing
    assign end_step  = item_reg.info_last ? STEP_CLOSE : STEP_INFO;
    assign last_step = (step_reg == end_step);
    assign emit      = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || (emit && last_step);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        step_next       = step_reg;
        frame_open_next = frame_open_reg;
        if (emit)
        begin
            if (last_step)
                item_valid_next = 1'b0;
            else
                step_next = step_reg + 1'b1;
        end
        if (in_fire)
        begin
            item_valid_next = 1'b1;
            step_next       = frame_open_reg ? STEP_INFO : STEP_OPEN;
            frame_open_next = !in_data.info_last;
        end
    end

    // FCS covers the address octets through the info byte
    always_comb
    begin
        fcs_next = fcs_reg;
        if (emit && step_reg == STEP_OPEN)
            fcs_next = FCS_INIT;
        else if (emit && step_reg >= STEP_DEST0 && step_reg <= STEP_INFO)
            fcs_next = fcs_byte(fcs_reg, cur_byte);
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.frame_byte = cur_byte;
            out_next.frame_end  = (step_reg == STEP_CLOSE);
            out_next.run_end    = last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= STEP_OPEN;
            frame_open_reg <= 1'b0;
            fcs_reg        <= FCS_INIT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            step_reg       <= step_next;
            frame_open_reg <= frame_open_next;
            fcs_reg        <= fcs_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_data;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> step_reg <= STEP_CLOSE)
        else $error("step beyond closing flag");

    a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.frame_end |-> out_reg.run_end)
        else $error("closing flag not last byte of run");

    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> item_valid_reg)
        else $error("accepted beat not held");

    a_fcs_init: assert property (@(posedge clk) disable iff (!rst_n)
        emit && step_reg == STEP_OPEN |=> fcs_reg == FCS_INIT)
        else $error("FCS not restarted at opening flag");

    a_open_only_new_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && frame_open_reg |=> step_reg == STEP_INFO)
        else $error("header repeated inside a frame");

endmodule
